// File: rtl/irdim_pkg.sv
// Shared types and constants for the IR remote dimmer.
`default_nettype none
package irdim_pkg;

    // item kinds
    localparam logic [1:0] KIND_TICK   = 2'd0;
    localparam logic [1:0] KIND_IR     = 2'd1;
    localparam logic [1:0] KIND_BUTTON = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_UP_FIRST  = 2'd0;
    localparam logic [1:0] CFG_UP_SECOND = 2'd1;
    localparam logic [1:0] CFG_LEVEL_TOP = 2'd2;

    localparam logic [31:0] UP_FIRST_RST  = 32'hbe40_7788;
    localparam logic [31:0] UP_SECOND_RST = 32'hbe40_bf40;
    localparam logic [7:0]  LEVEL_TOP_RST = 8'd100;
    localparam logic [7:0]  BRIGHT_RST    = 8'd100;

    // IR interval bands
    localparam logic [15:0] IGN_LO    = 16'd900;
    localparam logic [15:0] IGN_HI    = 16'd950;
    localparam logic [15:0] RPT_LO    = 16'd110;
    localparam logic [15:0] RPT_HI    = 16'd120;
    localparam logic [15:0] HDR_MIN   = 16'd100;
    localparam logic [15:0] ONE_BELOW = 16'd16;

    localparam logic [5:0] POS_START = 6'd32;
    localparam logic [5:0] POS_SKIP  = 6'd16;

    localparam logic [7:0] BRIGHT_MAX = 8'd10;

    typedef struct packed {
        logic        vld;
        logic [31:0] code;
    } t_code_evt;

endpackage
`default_nettype wire

// File: rtl/ir_remote_dimmer_unit.sv
// IR remote dimmer top level: input register, decode/level logic, result register.
// Usage:
//   Input channel: i_in_valid / o_in_stall with i_kind and i_interval. A request
//   is taken on a rising edge with valid high and stall low. Kind 0 is a PWM tick,
//   1 an IR interval, 2 a button press; kind 3 leaves the state alone.
//   Output channel: o_out_valid / i_out_stall with o_lamp_on, o_level,
//   o_code_valid and o_code, one result per input request, in order.
//   Config channel: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data;
//   ready is always high. Index 0 and 1 are the up-codes, index 2 is level_top.
//   Write config only while the block is idle.
// Timing:
//   A request passes through the input register, then the result register, where
//   its result is valid and can be taken; an output stall can hold it in between.
//   Throughput is one request per cycle when the output is not stalled; the
//   single pass of compare and shift logic between the registers sets that figure.
// Reset (synchronous, active low) clears both stages, the decoder state and
//   the ticker, and loads brightness 100 and the default config.
// Stall: when the receiver stalls and the result register is full, a full input
//   register holds and o_in_stall rises until the result is taken.
`default_nettype none
module ir_remote_dimmer_unit
    import irdim_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_kind,
    input  wire logic [15:0] i_interval,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_lamp_on,
    output logic [7:0]       o_level,
    output logic             o_code_valid,
    output logic [31:0]      o_code,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    logic [31:0] r_up_first, r_up_second;
    logic [7:0]  r_level_top;

    logic        r_in_vld;
    logic [1:0]  r_kind;
    logic [15:0] r_interval;

    logic        advance;
    t_code_evt   evt, ir_evt;
    logic        lamp_on;
    logic [7:0]  level;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up_first  <= UP_FIRST_RST;
            r_up_second <= UP_SECOND_RST;
            r_level_top <= LEVEL_TOP_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_UP_FIRST:  r_up_first  <= i_cfg_data;
                CFG_UP_SECOND: r_up_second <= i_cfg_data;
                CFG_LEVEL_TOP: r_level_top <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // stage 1 moves into the result register when that is empty or draining
    assign advance    = r_in_vld && (!o_out_valid || !i_out_stall);
    assign o_in_stall = r_in_vld && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_kind     <= i_kind;
            r_interval <= i_interval;
        end
    end

    irdim_ir u_ir (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (advance && r_kind == KIND_IR),
        .i_interval (r_interval),
        .o_evt      (ir_evt)
    );

    always_comb begin
        evt = ir_evt;
        if (r_kind != KIND_IR) begin
            evt = '0;
        end
    end

    irdim_lamp u_lamp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (advance),
        .i_kind      (r_kind),
        .i_evt       (evt),
        .i_up_first  (r_up_first),
        .i_up_second (r_up_second),
        .i_level_top (r_level_top),
        .o_lamp_on   (lamp_on),
        .o_level     (level)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (advance) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            o_lamp_on    <= lamp_on;
            o_level      <= level;
            o_code_valid <= evt.vld;
            o_code       <= evt.code;
        end
    end

endmodule
`default_nettype wire

// File: rtl/irdim_ir.sv
// IR interval decoder: header, data bits, repeat and code delivery.
`default_nettype none
module irdim_ir
    import irdim_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic [15:0] i_interval,
    output t_code_evt        o_evt
);

    logic [5:0]  r_bit_pos, n_bit_pos;
    logic [31:0] r_shift, n_shift;
    logic [31:0] r_last, n_last;
    logic [5:0]  pos;
    logic        bitv;

    always_comb begin
        n_bit_pos  = r_bit_pos;
        n_shift    = r_shift;
        n_last     = r_last;
        o_evt.vld  = 1'b0;
        o_evt.code = '0;
        pos        = (r_bit_pos == POS_SKIP) ? POS_SKIP - 6'd1 : r_bit_pos;
        bitv       = (i_interval < ONE_BELOW);
        if (i_interval > IGN_LO && i_interval < IGN_HI) begin
            // ignored band
        end else if (i_interval > RPT_LO && i_interval < RPT_HI && r_last != '0) begin
            o_evt.vld  = 1'b1;
            o_evt.code = r_last;
        end else if (i_interval > HDR_MIN) begin
            n_bit_pos = POS_START;
            n_shift   = '0;
        end else begin
            // positions at 32 and above shift the bit out entirely
            if (!pos[5]) begin
                n_shift[pos[4:0]] = r_shift[pos[4:0]] | bitv;
            end
            if (pos <= 6'd1) begin
                o_evt.vld  = 1'b1;
                o_evt.code = n_shift;
                n_bit_pos  = POS_START;
            end else begin
                n_bit_pos = pos - 6'd1;
            end
        end
        if (o_evt.vld) begin
            n_last = o_evt.code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_pos <= '0;
            r_shift   <= '0;
            r_last    <= '0;
        end else if (i_en) begin
            r_bit_pos <= n_bit_pos;
            r_shift   <= n_shift;
            r_last    <= n_last;
        end
    end

endmodule
`default_nettype wire

// File: rtl/irdim_lamp.sv
// PWM ticker and brightness level, with the lamp compare.
`default_nettype none
module irdim_lamp
    import irdim_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic [1:0]  i_kind,
    input  wire t_code_evt   i_evt,
    input  wire logic [31:0] i_up_first,
    input  wire logic [31:0] i_up_second,
    input  wire logic [7:0]  i_level_top,
    output logic             o_lamp_on,
    output logic [7:0]       o_level
);

    logic [7:0] r_ticker, n_ticker;
    logic [7:0] r_bright, n_bright;
    logic [8:0] tick_inc;

    assign tick_inc = {1'b0, r_ticker} + 9'd1;

    always_comb begin
        n_ticker = r_ticker;
        n_bright = r_bright;
        case (i_kind)
            KIND_TICK: begin
                n_ticker = (tick_inc > {1'b0, i_level_top}) ? 8'd0 : tick_inc[7:0];
            end
            KIND_IR: begin
                if (i_evt.vld) begin
                    if (i_evt.code == i_up_first || i_evt.code == i_up_second) begin
                        n_bright = (r_bright >= BRIGHT_MAX) ? BRIGHT_MAX : r_bright + 8'd1;
                    end else begin
                        n_bright = (r_bright == 8'd0) ? 8'd0 : r_bright - 8'd1;
                    end
                end
            end
            KIND_BUTTON: begin
                n_bright = (r_bright <= 8'd1) ? i_level_top : r_bright - 8'd1;
            end
            default: begin
            end
        endcase
    end

    assign o_lamp_on = (n_bright > n_ticker);
    assign o_level   = n_bright;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticker <= '0;
            r_bright <= BRIGHT_RST;
        end else if (i_en) begin
            r_ticker <= n_ticker;
            r_bright <= n_bright;
        end
    end

endmodule
`default_nettype wire
